// ----- hw/rtl/lbc_pkg.sv -----
// Shared types, constants and round functions for the lightweight block cipher.
package lbc_pkg;

  localparam int Rounds = 32;

  typedef logic [7:0][7:0] state_t;
  typedef logic [3:0][7:0] rkey_t;

  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow  = 2'd1;

  localparam logic [7:0] Delta [128] = '{
    8'h5A, 8'h6D, 8'h36, 8'h1B, 8'h0D, 8'h06, 8'h03, 8'h41,
    8'h60, 8'h30, 8'h18, 8'h4C, 8'h66, 8'h33, 8'h59, 8'h2C,
    8'h56, 8'h2B, 8'h15, 8'h4A, 8'h65, 8'h72, 8'h39, 8'h1C,
    8'h4E, 8'h67, 8'h73, 8'h79, 8'h3C, 8'h5E, 8'h6F, 8'h37,
    8'h5B, 8'h2D, 8'h16, 8'h0B, 8'h05, 8'h42, 8'h21, 8'h50,
    8'h28, 8'h54, 8'h2A, 8'h55, 8'h6A, 8'h75, 8'h7A, 8'h7D,
    8'h3E, 8'h5F, 8'h2F, 8'h17, 8'h4B, 8'h25, 8'h52, 8'h29,
    8'h14, 8'h0A, 8'h45, 8'h62, 8'h31, 8'h58, 8'h6C, 8'h76,
    8'h3B, 8'h1D, 8'h0E, 8'h47, 8'h63, 8'h71, 8'h78, 8'h7C,
    8'h7E, 8'h7F, 8'h3F, 8'h1F, 8'h0F, 8'h07, 8'h43, 8'h61,
    8'h70, 8'h38, 8'h5C, 8'h6E, 8'h77, 8'h7B, 8'h3D, 8'h1E,
    8'h4F, 8'h27, 8'h53, 8'h69, 8'h34, 8'h1A, 8'h4D, 8'h26,
    8'h13, 8'h49, 8'h24, 8'h12, 8'h09, 8'h04, 8'h02, 8'h01,
    8'h40, 8'h20, 8'h10, 8'h08, 8'h44, 8'h22, 8'h11, 8'h48,
    8'h64, 8'h32, 8'h19, 8'h0C, 8'h46, 8'h23, 8'h51, 8'h68,
    8'h74, 8'h3A, 8'h5D, 8'h2E, 8'h57, 8'h6B, 8'h35, 8'h5A
  };

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] fa(input logic [7:0] v);
    fa = rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 7);
  endfunction

  function automatic logic [7:0] fb(input logic [7:0] v);
    fb = rotl8(v, 3) ^ rotl8(v, 4) ^ rotl8(v, 6);
  endfunction

  // Subkey n is a master key byte plus a delta byte; n is a constant.
  function automatic logic [7:0] subkey(input logic [127:0] key, input int n);
    int i;
    int j;
    int m;
    i = n / 16;
    j = n % 16;
    if (j < 8) m = (j - i) & 7;
    else m = ((j - 8 - i) & 7) + 8;
    subkey = key[8*m +: 8] + Delta[n];
  endfunction

endpackage

// ----- hw/rtl/lightweight_block_cipher_64_128.sv -----
// Top level of the 64-bit block, 128-bit key lightweight block cipher.
// A chain of 32 round cells, one round per cell, takes one block per cycle
// while the output is not stalled, and returns each result from the last cell's
// register; whitening is done at the chain's ends. Encryption and decryption
// may be mixed freely. When the output is stalled while a result waits, the
// whole chain holds. The key must be written only while no block is in flight.
module lightweight_block_cipher_64_128 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [63:0] block_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] block_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import lbc_pkg::*;

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic [127:0] key;
  logic [7:0]   wk [8];
  logic         adv;
  logic         vv [Rounds+1];
  logic         dv [Rounds+1];
  state_t       st [Rounds+1];
  state_t       b;
  state_t       x;
  state_t       o;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgKeyHigh: key_high <= cfg_data;
        CfgKeyLow:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key = {key_high, key_low};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wk[i]     = key[8*(i+12) +: 8];
      wk[i + 4] = key[8*i +: 8];
    end
  end

  assign adv      = !vv[Rounds] || !out_stall;
  assign in_stall = !adv;

  // Input whitening.
  always_comb begin
    b = block_in;
    x = b;
    if (!func) begin
      x[0] = b[0] + wk[0];
      x[2] = b[2] ^ wk[1];
      x[4] = b[4] + wk[2];
      x[6] = b[6] ^ wk[3];
    end else begin
      x[2] = b[1];
      x[4] = b[3];
      x[6] = b[5];
      x[0] = b[7];
      x[1] = b[0] - wk[4];
      x[3] = b[2] ^ wk[5];
      x[5] = b[4] - wk[6];
      x[7] = b[6] ^ wk[7];
    end
  end

  assign vv[0] = in_valid;
  assign dv[0] = func;
  assign st[0] = x;

  for (genvar k = 0; k < Rounds; k++) begin : g_cell
    rkey_t ske;
    rkey_t skd;
    for (genvar t = 0; t < 4; t++) begin : g_sk
      assign ske[t] = subkey(key, 4 * k + t);
      assign skd[t] = subkey(key, 4 * (Rounds - 1 - k) + t);
    end
    lbc_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .valid_in  (vv[k]),
      .dec_in    (dv[k]),
      .st_in     (st[k]),
      .sk_enc    (ske),
      .sk_dec    (skd),
      .valid_out (vv[k+1]),
      .dec_out   (dv[k+1]),
      .st_out    (st[k+1])
    );
  end

  // Output whitening from the last cell's register.
  always_comb begin
    o = st[Rounds];
    if (!dv[Rounds]) begin
      o[1] = st[Rounds][2];
      o[3] = st[Rounds][4];
      o[5] = st[Rounds][6];
      o[7] = st[Rounds][0];
      o[0] = st[Rounds][1] + wk[4];
      o[2] = st[Rounds][3] ^ wk[5];
      o[4] = st[Rounds][5] + wk[6];
      o[6] = st[Rounds][7] ^ wk[7];
    end else begin
      o[0] = st[Rounds][0] - wk[0];
      o[2] = st[Rounds][2] ^ wk[1];
      o[4] = st[Rounds][4] - wk[2];
      o[6] = st[Rounds][6] ^ wk[3];
    end
  end

  assign out_valid = vv[Rounds];
  assign block_out = o;

endmodule

// ----- hw/rtl/lbc_round_cell.sv -----
// One round cell of the cipher pipeline, encrypting or decrypting per item.
module lbc_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_in,
  input  logic            dec_in,
  input  lbc_pkg::state_t st_in,
  input  lbc_pkg::rkey_t  sk_enc,
  input  lbc_pkg::rkey_t  sk_dec,
  output logic            valid_out,
  output logic            dec_out,
  output lbc_pkg::state_t st_out
);
  import lbc_pkg::*;

  state_t t;
  state_t s;
  state_t st_next;

  // The state is kept rotated so every round works on fixed byte lanes.
  always_comb begin
    t = st_in;
    s = st_in;
    st_next = st_in;
    if (!dec_in) begin
      t[7] = st_in[7] ^ (fa(st_in[6]) + sk_enc[3]);
      t[5] = st_in[5] + (fb(st_in[4]) ^ sk_enc[2]);
      t[3] = st_in[3] ^ (fa(st_in[2]) + sk_enc[1]);
      t[1] = st_in[1] + (fb(st_in[0]) ^ sk_enc[0]);
      for (int i = 0; i < 8; i++) st_next[i] = t[(i + 7) % 8];
    end else begin
      for (int i = 0; i < 8; i++) s[i] = st_in[(i + 1) % 8];
      st_next = s;
      st_next[1] = s[1] - (fb(s[0]) ^ sk_dec[0]);
      st_next[3] = s[3] ^ (fa(s[2]) + sk_dec[1]);
      st_next[5] = s[5] - (fb(s[4]) ^ sk_dec[2]);
      st_next[7] = s[7] ^ (fa(s[6]) + sk_dec[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_out <= dec_in;
      st_out  <= st_next;
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench for the lightweight block cipher: random and directed blocks checked against a predictor.
module tb_top;
  import lbc_pkg::*;

  localparam logic [1:0] CfgUnused = 2'd2;
  localparam logic [1:0] CfgUnused3 = 2'd3;
  localparam logic FuncEnc = 1'b0;
  localparam logic FuncDec = 1'b1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [63:0] block_in;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] block_out;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  lightweight_block_cipher_64_128 dut (.*);

  logic [63:0] key_hi_m, key_lo_m;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;

  function automatic logic [7:0] rot(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] mix_a(input logic [7:0] v);
    return rot(v, 1) ^ rot(v, 2) ^ rot(v, 7);
  endfunction

  function automatic logic [7:0] mix_b(input logic [7:0] v);
    return rot(v, 3) ^ rot(v, 4) ^ rot(v, 6);
  endfunction

  // Computes the cipher result of one block under the modeled key.
  function automatic logic [63:0] cipher_block(input logic f, input logic [63:0] blk);
    logic [127:0] k;
    logic [7:0] wk [8];
    logic [7:0] sk [128];
    logic [7:0] b [8];
    logic [7:0] x [8];
    logic [7:0] dtab [128];
    int m, r;
    int p [8];
    logic [63:0] res;
    dtab[0] = 8'h5A;
    // The delta table comes from a 7-bit LFSR: s[i] = s[i-4] ^ s[i-7] on bits.
    for (int i = 1; i < 128; i++) begin
      dtab[i] = {1'b0, dtab[i-1][0] ^ dtab[i-1][3], dtab[i-1][6:1]};
    end
    k = {key_hi_m, key_lo_m};
    for (int i = 0; i < 4; i++) begin
      wk[i] = k[8*(i+12) +: 8];
      wk[i+4] = k[8*i +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        m = (j - i) & 7;
        sk[16*i+j] = k[8*m +: 8] + dtab[16*i+j];
        sk[16*i+j+8] = k[8*(m+8) +: 8] + dtab[16*i+j+8];
      end
    end
    for (int j = 0; j < 8; j++) b[j] = blk[8*j +: 8];
    if (f == FuncEnc) begin
      x[1] = b[1]; x[3] = b[3]; x[5] = b[5]; x[7] = b[7];
      x[0] = b[0] + wk[0]; x[2] = b[2] ^ wk[1];
      x[4] = b[4] + wk[2]; x[6] = b[6] ^ wk[3];
      for (r = 0; r < 32; r++) begin
        for (int q = 0; q < 8; q++) p[q] = (7 - q - r) & 7;
        x[p[0]] = x[p[0]] ^ (mix_a(x[p[1]]) + sk[4*r+3]);
        x[p[2]] = x[p[2]] + (mix_b(x[p[3]]) ^ sk[4*r+2]);
        x[p[4]] = x[p[4]] ^ (mix_a(x[p[5]]) + sk[4*r+1]);
        x[p[6]] = x[p[6]] + (mix_b(x[p[7]]) ^ sk[4*r]);
      end
      b[1] = x[2]; b[3] = x[4]; b[5] = x[6]; b[7] = x[0];
      b[0] = x[1] + wk[4]; b[2] = x[3] ^ wk[5];
      b[4] = x[5] + wk[6]; b[6] = x[7] ^ wk[7];
    end else begin
      x[2] = b[1]; x[4] = b[3]; x[6] = b[5]; x[0] = b[7];
      x[1] = b[0] - wk[4]; x[3] = b[2] ^ wk[5];
      x[5] = b[4] - wk[6]; x[7] = b[6] ^ wk[7];
      for (r = 31; r >= 0; r--) begin
        for (int q = 0; q < 8; q++) p[q] = (7 - q - r) & 7;
        x[p[6]] = x[p[6]] - (mix_b(x[p[7]]) ^ sk[4*r]);
        x[p[4]] = x[p[4]] ^ (mix_a(x[p[5]]) + sk[4*r+1]);
        x[p[2]] = x[p[2]] - (mix_b(x[p[3]]) ^ sk[4*r+2]);
        x[p[0]] = x[p[0]] ^ (mix_a(x[p[1]]) + sk[4*r+3]);
      end
      b[1] = x[1]; b[3] = x[3]; b[5] = x[5]; b[7] = x[7];
      b[0] = x[0] - wk[0]; b[2] = x[2] ^ wk[1];
      b[4] = x[4] - wk[2]; b[6] = x[6] ^ wk[3];
    end
    for (int j = 0; j < 8; j++) res[8*j +: 8] = b[j];
    return res;
  endfunction

  class block_scoreboard;
    logic [63:0] pending [$];
    int errors;

    function void note_block(input logic f, input logic [63:0] blk);
      pending.push_back(cipher_block(f, blk));
    endfunction

    function void check_block(input logic [63:0] got);
      logic [63:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected block_out expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending.pop_front();
        if (want !== got) begin
          $display("%0t: block_out mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  block_scoreboard sb;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Output side: random stall plus an optional long hold-off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_block(block_out);
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The extra cycle lets back-to-back writes drive each signal once per edge.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgKeyHigh) key_hi_m = val;
    else if (idx == CfgKeyLow) key_lo_m = val;
    @(posedge clk);
  endtask

  // Valid stays high after the transfer; the next send or drain replaces it.
  task automatic send_block(input logic f, input logic [63:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    block_in <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_block(f, blk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge_val(input int sel);
    case (sel)
      0: return 64'h0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h1;
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [63:0] pt;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0; func = 1'b0; block_in = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    key_hi_m = '0; key_lo_m = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the never-written zero key, field extremes, both operations.
    for (int i = 0; i < 4; i++) begin
      send_block(FuncEnc, edge_val(i));
      send_block(FuncDec, edge_val(i));
    end
    drain();
    write_reg(CfgKeyHigh, 64'h0011_2233_4455_6677);
    write_reg(CfgKeyLow, 64'h8899_aabb_ccdd_eeff);
    write_reg(CfgUnused, '1);
    write_reg(CfgUnused3, 64'h5555);
    send_block(FuncEnc, 64'h0);
    send_block(FuncDec, 64'h0);
    send_block(FuncEnc, 64'h0123_4567_89ab_cdef);
    drain();
    write_reg(CfgKeyHigh, '1);
    write_reg(CfgKeyLow, '1);
    send_block(FuncEnc, '1);
    send_block(FuncDec, '1);
    drain();

    // Random phases with several idling patterns and keys.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      write_reg(CfgKeyHigh, edge_val($urandom_range(6)));
      write_reg(CfgKeyLow, edge_val($urandom_range(6)));
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (150) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int n = 0; n < 105; n++) begin
        pt = rand64();
        send_block(FuncEnc, pt);
        // Round trip: the fresh ciphertext is sent back for decryption and checked against the predictor.
        send_block(FuncDec, cipher_block(FuncEnc, pt));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[lightweight_block_cipher_64_128] OK");
    end else begin
      $display("[lightweight_block_cipher_64_128] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[lightweight_block_cipher_64_128] ERROR");
    $finish;
  end

endmodule

// ----- lightweight_block_cipher_64_128.f -----
hw/rtl/lbc_pkg.sv
hw/rtl/lbc_round_cell.sv
hw/rtl/lightweight_block_cipher_64_128.sv
test/tb_top.sv
